// ===== rtl/cpb_pkg.sv =====
// Package for the capture pixel blender: field widths, register indexes,
// capture mode codes and the configuration bundle. No dependencies.
`default_nettype none
package cpb_pkg;

   localparam int PIXEL_W   = 18;
   localparam int WORD_W    = 16;
   localparam int CHAN_W    = 6;
   localparam int OUT_CH_W  = 5;
   localparam int FACTOR_W  = 5;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 5;

   localparam logic [CSR_IDX_W-1:0] REG_FACTOR_A    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FACTOR_B    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CAPTURE_MODE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B_FROM_FIFO = 4'd3;

   localparam logic [MODE_W-1:0] MODE_A_ONLY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_B_ONLY = 2'd1;

   localparam logic [FACTOR_W-1:0] FACTOR_MAX = 5'd16;
   localparam logic [FACTOR_W-1:0] FACTOR_NONE = 5'd0;
   localparam logic [WORD_W-1:0]   MARK_BIT   = 16'h8000;

   typedef struct packed {
      logic [FACTOR_W-1:0] fa;
      logic [FACTOR_W-1:0] fb;
      logic                b_from_fifo;
   } cpb_cfg_type;

endpackage
`default_nettype wire

// ===== rtl/capture_pixel_blend_top.sv =====
// Top level of the capture pixel blender: input register, blend logic and
// result register. Depends on cpb_pkg, cpb_csr and cpb_blend.
//
// Takes one A/B pixel pair per clock while req_stall is low and returns one
// BGR555 word with bit 15 set per pair. The pair sits in an input register,
// the blend (two small multiplies per channel, round, divide by 32, saturate
// at 31) is a single combinational pass, and the result register holds the
// word; a new pair is accepted while a finished word waits, so throughput is
// one transaction per clock unless the result side stalls. Registers are
// written through the csr_ port, always ready, and take effect on pairs not
// yet in the result register; write them only while the block is idle.
`default_nettype none
module capture_pixel_blend_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [cpb_pkg::PIXEL_W-1:0]   req_pixel_a,
   input  wire logic [cpb_pkg::PIXEL_W-1:0]   req_pixel_b,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [cpb_pkg::WORD_W-1:0]         rsp_captured_word,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cpb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cpb_pkg::CSR_DAT_W-1:0] csr_data
);
   import cpb_pkg::*;

   cpb_cfg_type        cfg;
   logic               in_valid_ff, in_valid_in;
   logic [PIXEL_W-1:0] pa_ff, pb_ff;
   logic               out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic               out_free;
   logic               req_take;

   cpb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cpb_blend u_blend (
      .pixel_a (pa_ff),
      .pixel_b (pb_ff),
      .cfg     (cfg),
      .word    (word_in)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (out_free) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pa_ff <= req_pixel_a;
         pb_ff <= req_pixel_b;
      end
      if (out_free && in_valid_ff) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_captured_word = word_ff;

endmodule
`default_nettype wire

// ===== rtl/cpb_csr.sv =====
// Configuration registers of the capture pixel blender; resolves the capture
// mode and factor clamp into the effective weights. Depends on cpb_pkg.
`default_nettype none
module cpb_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cpb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cpb_pkg::CSR_DAT_W-1:0] csr_data,
   output cpb_pkg::cpb_cfg_type               cfg
);
   import cpb_pkg::*;

   logic [FACTOR_W-1:0] factor_a_ff;
   logic [FACTOR_W-1:0] factor_b_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic                b_fifo_ff;
   logic                wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_a_ff <= '0;
         factor_b_ff <= '0;
         mode_ff     <= '0;
         b_fifo_ff   <= 1'b0;
      end else if (wr_en) begin
         case (csr_index)
            REG_FACTOR_A:     factor_a_ff <= csr_data;
            REG_FACTOR_B:     factor_b_ff <= csr_data;
            REG_CAPTURE_MODE: mode_ff     <= csr_data[MODE_W-1:0];
            REG_B_FROM_FIFO:  b_fifo_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.b_from_fifo = b_fifo_ff;
      case (mode_ff)
         MODE_A_ONLY: begin
            cfg.fa = FACTOR_MAX;
            cfg.fb = FACTOR_NONE;
         end
         MODE_B_ONLY: begin
            cfg.fa = FACTOR_NONE;
            cfg.fb = FACTOR_MAX;
         end
         default: begin
            cfg.fa = factor_a_ff[FACTOR_W-1] ? FACTOR_MAX : factor_a_ff;
            cfg.fb = factor_b_ff[FACTOR_W-1] ? FACTOR_MAX : factor_b_ff;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/cpb_blend.sv =====
// Combinational per-channel weighted blend of the two pixels into a BGR555
// word. Depends on cpb_pkg.
`default_nettype none
module cpb_blend (
   input  wire logic [cpb_pkg::PIXEL_W-1:0] pixel_a,
   input  wire logic [cpb_pkg::PIXEL_W-1:0] pixel_b,
   input  wire cpb_pkg::cpb_cfg_type        cfg,
   output logic [cpb_pkg::WORD_W-1:0]       word
);
   import cpb_pkg::*;

   localparam int SUM_W = 12;
   localparam logic [SUM_W-1:0] ROUND_BIAS = 12'd8;

   function automatic logic [OUT_CH_W-1:0] mix_channel(
      input logic [CHAN_W-1:0]   a,
      input logic [CHAN_W-1:0]   b,
      input logic [FACTOR_W-1:0] fa,
      input logic [FACTOR_W-1:0] fb
   );
      logic [SUM_W-1:0]  sum;
      logic [CHAN_W-1:0] q;
      sum = SUM_W'(a * fa) + SUM_W'(b * fb) + ROUND_BIAS;
      q   = sum[10:5];
      return q[CHAN_W-1] ? {OUT_CH_W{1'b1}} : q[OUT_CH_W-1:0];
   endfunction

   logic [CHAN_W-1:0]   ch_a [3];
   logic [CHAN_W-1:0]   ch_b [3];
   logic [OUT_CH_W-1:0] ch_o [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ch_a[i] = pixel_a[i*CHAN_W +: CHAN_W];
         if (cfg.b_from_fifo) begin
            ch_b[i] = pixel_b[i*CHAN_W +: CHAN_W];
         end else begin
            ch_b[i] = {pixel_b[i*OUT_CH_W +: OUT_CH_W], 1'b0};
         end
         ch_o[i] = mix_channel(ch_a[i], ch_b[i], cfg.fa, cfg.fb);
      end
      word = MARK_BIT | {1'b0, ch_o[2], ch_o[1], ch_o[0]};
   end

endmodule
`default_nettype wire

// ===== rtl/cpb_checker.sv =====
// Port-level checks for the capture pixel blender, bound to the top level.
// Depends on cpb_pkg and capture_pixel_blend_top.
`default_nettype none
module cpb_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [cpb_pkg::WORD_W-1:0]  rsp_captured_word,
   input wire logic                        csr_ready
);
   import cpb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_captured_word))
      else $error("stalled result changed");

   a_mark_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_captured_word[WORD_W-1])
      else $error("result without mark bit");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   a_req_reaches_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("accepted transaction produced no result");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port not ready");

endmodule

bind capture_pixel_blend_top cpb_checker u_cpb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_captured_word (rsp_captured_word),
   .csr_ready         (csr_ready)
);
`default_nettype wire

// ===== sim/capture_pixel_blend_top_test.sv =====
`timescale 1ns / 100ps
// Testbench for capture_pixel_blend_top: random and directed pixel pairs checked
// against a scoreboard that predicts each BGR555 capture word. Depends on cpb_pkg.

import cpb_pkg::*;

class blend_scoreboard;
   logic [FACTOR_W-1:0] factor_a;
   logic [FACTOR_W-1:0] factor_b;
   logic [MODE_W-1:0]   capture_mode;
   logic                b_from_fifo;
   logic [WORD_W-1:0]   expected_words[$];
   int                  errors;

   function new();
      factor_a     = '0;
      factor_b     = '0;
      capture_mode = '0;
      b_from_fifo  = 1'b0;
      errors       = 0;
   endfunction

   function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      case (idx)
         REG_FACTOR_A:     factor_a     = data;
         REG_FACTOR_B:     factor_b     = data;
         REG_CAPTURE_MODE: capture_mode = data[MODE_W-1:0];
         REG_B_FROM_FIFO:  b_from_fifo  = data[0];
         default: ;
      endcase
   endfunction

   function logic [OUT_CH_W-1:0] blend_channel(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                               logic [FACTOR_W-1:0] wa,
                                               logic [FACTOR_W-1:0] wb);
      logic [11:0] sum;
      logic [6:0]  quot;
      sum  = 12'(a) * 12'(wa) + 12'(b) * 12'(wb) + 12'd8;
      quot = sum[11:5];
      return (quot > 7'd31) ? 5'd31 : quot[OUT_CH_W-1:0];
   endfunction

   function void note_pair(logic [PIXEL_W-1:0] pa, logic [PIXEL_W-1:0] pb);
      logic [FACTOR_W-1:0] wa;
      logic [FACTOR_W-1:0] wb;
      logic [CHAN_W-1:0]   br;
      logic [CHAN_W-1:0]   bg;
      logic [CHAN_W-1:0]   bb;
      logic [WORD_W-1:0]   word;
      wa = (factor_a > FACTOR_MAX) ? FACTOR_MAX : factor_a;
      wb = (factor_b > FACTOR_MAX) ? FACTOR_MAX : factor_b;
      case (capture_mode)
         MODE_A_ONLY: begin
            wa = FACTOR_MAX;
            wb = FACTOR_NONE;
         end
         MODE_B_ONLY: begin
            wa = FACTOR_NONE;
            wb = FACTOR_MAX;
         end
         default: ;
      endcase
      if (b_from_fifo) begin
         br = pb[5:0];
         bg = pb[11:6];
         bb = pb[17:12];
      end else begin
         br = {pb[4:0], 1'b0};
         bg = {pb[9:5], 1'b0};
         bb = {pb[14:10], 1'b0};
      end
      word = MARK_BIT | {1'b0, blend_channel(pa[17:12], bb, wa, wb),
                         blend_channel(pa[11:6], bg, wa, wb),
                         blend_channel(pa[5:0], br, wa, wb)};
      expected_words.push_back(word);
   endfunction

   function void check_word(logic [WORD_W-1:0] actual);
      logic [WORD_W-1:0] expected;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected captured_word, expected none actual %h", $time, actual);
         errors++;
      end else begin
         expected = expected_words.pop_front();
         if (actual !== expected) begin
            $display("%0t: captured_word mismatch, expected %h actual %h",
                     $time, expected, actual);
            errors++;
         end
      end
   endfunction
endclass

module capture_pixel_blend_top_test;

   localparam logic [MODE_W-1:0]    MODE_BLEND     = 2'd2;
   localparam logic [MODE_W-1:0]    MODE_BLEND_ALT = 2'd3;
   localparam logic                 B_RAW555       = 1'b0;
   localparam logic                 B_FIFO666      = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED     = 4'd12;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [PIXEL_W-1:0] req_pixel_a;
   logic [PIXEL_W-1:0] req_pixel_b;
   logic rsp_valid;
   logic rsp_stall;
   logic [WORD_W-1:0] rsp_captured_word;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   logic send_idle_on;
   logic rsp_idle_on;
   logic long_hold_req;
   int   stall_left;
   int   quiet_cycles;

   blend_scoreboard sb;

   capture_pixel_blend_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_a       (req_pixel_a),
      .req_pixel_b       (req_pixel_b),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_captured_word (rsp_captured_word),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_pair(req_pixel_a, req_pixel_b);
         if (rsp_valid && !rsp_stall) sb.check_word(rsp_captured_word);
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold on request
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] pa, input logic [PIXEL_W-1:0] pb);
      int gap;
      gap = (send_idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_pixel_a <= pa;
      req_pixel_b <= pb;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and hold until every capture word is back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [CSR_DAT_W-1:0] pick_factor();
      case ($urandom_range(0, 5))
         0: return FACTOR_NONE;
         1: return FACTOR_MAX;
         2: return '1;
         3: return FACTOR_MAX + 5'd1;
         default: return CSR_DAT_W'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   initial begin
      int phase;
      int n;
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pixel_a   = '0;
      req_pixel_b   = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      send_idle_on  = 1'b1;
      rsp_idle_on   = 1'b1;
      long_hold_req = 1'b0;
      quiet_cycles  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: A only, raw BGR555 source
      send_pixel('0, '0);
      send_pixel('1, '1);
      send_pixel(18'h2AAAA, 18'h15555);
      wait_drained();
      // factors above sixteen, blend, saturation on every channel
      write_reg(REG_FACTOR_A, '1);
      write_reg(REG_FACTOR_B, '1);
      write_reg(REG_CAPTURE_MODE, CSR_DAT_W'(MODE_BLEND));
      write_reg(REG_B_FROM_FIFO, CSR_DAT_W'(B_FIFO666));
      send_pixel('1, '1);
      send_pixel('0, '0);
      send_pixel('1, '0);
      send_pixel('0, '1);
      wait_drained();
      // raw source with the unused high bits set
      write_reg(REG_B_FROM_FIFO, CSR_DAT_W'(B_RAW555));
      send_pixel('1, '1);
      send_pixel('0, 18'h38000);
      send_pixel(18'h15555, 18'h2AAAA);
      wait_drained();
      write_reg(REG_CAPTURE_MODE, CSR_DAT_W'(MODE_B_ONLY));
      write_reg(REG_FACTOR_A, FACTOR_MAX);
      write_reg(REG_FACTOR_B, FACTOR_MAX + 5'd1);
      send_pixel('1, 18'h07FFF);
      send_pixel('0, '0);
      send_pixel(18'h12345, '1);
      wait_drained();
      write_reg(REG_CAPTURE_MODE, CSR_DAT_W'(MODE_BLEND_ALT));
      write_reg(REG_FACTOR_A, FACTOR_NONE);
      write_reg(REG_FACTOR_B, FACTOR_NONE);
      send_pixel('1, '1);
      wait_drained();
      write_reg(REG_FACTOR_A, FACTOR_MAX);
      write_reg(REG_FACTOR_B, FACTOR_MAX);
      send_pixel('1, '1);
      send_pixel(18'h20820, 18'h3F03F);
      wait_drained();
      write_reg(REG_FACTOR_A, 5'd1);
      write_reg(REG_FACTOR_B, 5'd15);
      send_pixel(18'h3F03F, 18'h00FC0);
      wait_drained();
      // a write to an unused index must leave the settings alone
      write_reg(REG_UNUSED, '1);
      send_pixel('1, '0);

      for (phase = 0; phase < 11; phase++) begin
         wait_drained();
         write_reg(REG_FACTOR_A, pick_factor());
         write_reg(REG_FACTOR_B, pick_factor());
         write_reg(REG_CAPTURE_MODE, CSR_DAT_W'($urandom_range(0, 3)));
         write_reg(REG_B_FROM_FIFO, CSR_DAT_W'($urandom_range(0, 1)));
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_IDX_W'($urandom_range(REG_B_FROM_FIFO + 1, 15)),
                      CSR_DAT_W'($urandom_range(0, 31)));
         send_idle_on = (phase % 3 != 2);
         rsp_idle_on  = (phase % 4 != 1);
         if (phase == 5) begin
            long_hold_req = 1'b1;
            send_idle_on  = 1'b0;
         end
         for (n = 0; n < 150; n++) begin
            if (phase == 5 && n == 75) wait_drained();
            send_pixel(pick_pixel(), pick_pixel());
         end
      end

      wait_drained();
      send_idle_on = 1'b0;
      rsp_idle_on  = 1'b0;
      for (n = 0; n < 200; n++) send_pixel(pick_pixel(), pick_pixel());
      wait_drained();

      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
